@@ rtl/core/qrsa_pkg.sv @@
package qrsa_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 12;
  localparam int RGB_BITS   = 24;
  localparam int ROUND_BITS = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROUND_COUNT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_INVERSE_MODE = 3'd3;

  // Register reset values
  localparam logic [COORD_BITS-1:0] RST_FRAME_WIDTH  = 12'd1920;
  localparam logic [COORD_BITS-1:0] RST_FRAME_HEIGHT = 12'd1080;
  localparam logic [ROUND_BITS-1:0] RST_ROUND_COUNT  = 4'd3;
  localparam logic                  RST_INVERSE_MODE = 1'b0;

  // Quadrant codes in clockwise order; each code selects one move
  typedef enum logic [1:0] {
    QUAD_TL = 2'd0,  // move x by +half
    QUAD_TR = 2'd1,  // move y by +half
    QUAD_BR = 2'd2,  // move x by -half
    QUAD_BL = 2'd3   // move y by -half
  } quad_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic [RGB_BITS-1:0]   pixel_rgb;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic [RGB_BITS-1:0]   pixel_out;
  } out_item_t;

  // State of one item between rounds
  typedef struct packed {
    logic                  valid;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] lx;
    logic [COORD_BITS-1:0] ly;
    logic [COORD_BITS-1:0] ox;
    logic [COORD_BITS-1:0] oy;
    logic [COORD_BITS-1:0] hw;
    logic [COORD_BITS-1:0] hh;
    logic [RGB_BITS-1:0]   rgb;
  } stage_t;

  // Quadrant of a pixel from its half flags
  function automatic quad_t quad_of(input logic right, input logic bottom);
    quad_t q;
    case ({right, bottom})
      2'b00:   q = QUAD_TL;
      2'b10:   q = QUAD_TR;
      2'b11:   q = QUAD_BR;
      default: q = QUAD_BL;
    endcase
    return q;
  endfunction

endpackage

@@ rtl/core/quadrant_rotation_scramble_address.sv @@
// An accepted item strobes out_valid after the entry and MAX_ROUNDS stage registers.
// Throughput: one item per cycle, sustained; busy stays low since results cannot stall.
// Each recursion level is one pipeline stage (one halving, add/compare and move),
// so the depth is set by MAX_ROUNDS; unused levels pass items through unchanged.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults:
// width 1920, height 1080, three rounds, clockwise mode.
module quadrant_rotation_scramble_address #(
  parameter int MAX_ROUNDS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input items
  input  logic                                  start,
  output logic                                  busy,
  input  qrsa_pkg::in_item_t                    in_data,
  // result items
  output logic                                  out_valid,
  output qrsa_pkg::out_item_t                   out_data,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [qrsa_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [qrsa_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int CB = qrsa_pkg::COORD_BITS;
  localparam int RB = qrsa_pkg::ROUND_BITS;

  // configuration registers
  logic [CB-1:0] frame_width_r;
  logic [CB-1:0] frame_height_r;
  logic [RB-1:0] round_count_r;
  logic          inverse_mode_r;
  logic [RB-1:0] levels;

  logic in_accept;

  qrsa_pkg::stage_t stage_r   [0:MAX_ROUNDS];
  qrsa_pkg::stage_t stage_nxt [0:MAX_ROUNDS];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  // round count saturates at the pipeline depth
  assign levels = (round_count_r > RB'(MAX_ROUNDS)) ? RB'(MAX_ROUNDS) : round_count_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= qrsa_pkg::RST_FRAME_WIDTH;
      frame_height_r <= qrsa_pkg::RST_FRAME_HEIGHT;
      round_count_r  <= qrsa_pkg::RST_ROUND_COUNT;
      inverse_mode_r <= qrsa_pkg::RST_INVERSE_MODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        qrsa_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[CB-1:0];
        qrsa_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data[CB-1:0];
        qrsa_pkg::REG_ROUND_COUNT:  round_count_r  <= cfg_data[RB-1:0];
        qrsa_pkg::REG_INVERSE_MODE: inverse_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // entry stage and one stage per recursion level
  always_comb begin
    logic [CB-1:0]   hw_n;
    logic [CB-1:0]   hh_n;
    logic            right;
    logic            bottom;
    qrsa_pkg::quad_t q;

    stage_nxt[0].valid = in_accept;
    stage_nxt[0].sx    = in_data.src_x;
    stage_nxt[0].sy    = in_data.src_y;
    stage_nxt[0].lx    = in_data.src_x;
    stage_nxt[0].ly    = in_data.src_y;
    stage_nxt[0].ox    = '0;
    stage_nxt[0].oy    = '0;
    stage_nxt[0].hw    = frame_width_r;
    stage_nxt[0].hh    = frame_height_r;
    stage_nxt[0].rgb   = in_data.pixel_rgb;

    for (int i = 1; i <= MAX_ROUNDS; i++) begin
      stage_nxt[i] = stage_r[i-1];
      hw_n   = stage_r[i-1].hw >> 1;
      hh_n   = stage_r[i-1].hh >> 1;
      // origin plus half never exceeds the frame size, so no carry out
      right  = stage_r[i-1].sx >= (stage_r[i-1].ox + hw_n);
      bottom = stage_r[i-1].sy >= (stage_r[i-1].oy + hh_n);
      q      = qrsa_pkg::quad_of(right, bottom);
      if (inverse_mode_r) begin
        q = qrsa_pkg::quad_t'(q + 2'd1);
      end
      if (RB'(i - 1) < levels) begin
        stage_nxt[i].hw = hw_n;
        stage_nxt[i].hh = hh_n;
        case (q)
          qrsa_pkg::QUAD_TL: stage_nxt[i].lx = stage_r[i-1].lx + hw_n;
          qrsa_pkg::QUAD_TR: stage_nxt[i].ly = stage_r[i-1].ly + hh_n;
          qrsa_pkg::QUAD_BR: stage_nxt[i].lx = stage_r[i-1].lx - hw_n;
          qrsa_pkg::QUAD_BL: stage_nxt[i].ly = stage_r[i-1].ly - hh_n;
          default: ;
        endcase
        if (right) begin
          stage_nxt[i].ox = stage_r[i-1].ox + hw_n;
        end
        if (bottom) begin
          stage_nxt[i].oy = stage_r[i-1].oy + hh_n;
        end
      end
    end
  end

  // pipeline registers; reset empties every stage
  always_ff @(posedge clk) begin
    for (int i = 0; i <= MAX_ROUNDS; i++) begin
      if (!rst_n) begin
        stage_r[i] <= '0;
      end else begin
        stage_r[i] <= stage_nxt[i];
      end
    end
  end

  // last stage is the output register
  assign out_valid          = stage_r[MAX_ROUNDS].valid;
  assign out_data.dest_x    = stage_r[MAX_ROUNDS].lx;
  assign out_data.dest_y    = stage_r[MAX_ROUNDS].ly;
  assign out_data.pixel_out = stage_r[MAX_ROUNDS].rgb;

  // every accepted item comes out on out_valid after passing every stage register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##(MAX_ROUNDS+1) out_valid)
    else $error("accepted item did not reach the output");

  // no result without an item accepted at the right time
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, MAX_ROUNDS+1))
    else $error("result strobe without matching item");

  // pixel value travels with its coordinates
  a_pixel_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_out == $past(in_data.pixel_rgb, MAX_ROUNDS+1))
    else $error("pixel value changed in flight");

  // zero rounds map every pixel onto itself
  a_identity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && round_count_r == '0) |->
      (out_data.dest_x == $past(in_data.src_x, MAX_ROUNDS+1) &&
       out_data.dest_y == $past(in_data.src_y, MAX_ROUNDS+1)))
    else $error("zero rounds did not give identity");

endmodule
